[sv/adam_pkg.sv]
`default_nettype none

package adam_pkg;

    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 3'd3;

    localparam logic [15:0] BETA_FIRST_RESET    = 16'd58982;
    localparam logic [15:0] BETA_SECOND_RESET   = 16'd65470;
    localparam logic [23:0] LEARNING_RATE_RESET = 24'd16777;
    localparam logic [23:0] EPSILON_RESET       = 24'd1;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // Quotient bits of the bias correction, root bits, and quotient bits of the step.
    localparam int DIV1_STEPS = 48;
    localparam int SQRT_STEPS = 32;
    localparam int DIV2_STEPS = 31;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             in_range;
        logic             neg;
    } tag_t;

endpackage

`default_nettype wire

[sv/adam_weight_step.sv]
// Channel   Direction  Handshake                  Word
// item      in         item_valid / item_ready    weight_addr, gradient, last_of_vector
// result    out        result_valid / result_ready out_index, velocity, out_last
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One word enters per cycle unless the result side stalls or the clearing pass runs.
// Most of the pipeline depth comes from the bit-per-stage correction dividers, square root and step divider.
// After reset the moment stores are cleared one entry a cycle, so item_ready stays low
// until all min(WEIGHT_COUNT, 1024) entries are cleared; configuration writes are taken throughout.
// A stall on the result side freezes every stage together, so nothing is lost or repeated.
`default_nettype none

module adam_weight_step #(
    parameter int WEIGHT_COUNT = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [adam_pkg::IDX_W-1:0]        weight_addr,
    input  wire logic signed [31:0]                gradient,
    input  wire logic                              last_of_vector,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [adam_pkg::IDX_W-1:0]             out_index,
    output logic signed [31:0]                     velocity,
    output logic                                   out_last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [adam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [adam_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int MEM_DEPTH = (WEIGHT_COUNT < 1024) ? WEIGHT_COUNT : 1024;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int N1        = adam_pkg::DIV1_STEPS;
    localparam int NS        = adam_pkg::SQRT_STEPS;
    localparam int N2        = adam_pkg::DIV2_STEPS;

    function automatic logic [33:0] div_step(input logic [32:0] rem, input logic b,
                                             input logic [32:0] dsr);
        logic [33:0] part;
        logic        ge;
        part = {rem, b};
        ge   = part >= {1'b0, dsr};
        return {ge, 33'(ge ? part - {1'b0, dsr} : part)};
    endfunction

    // Configuration and step powers.
    logic [15:0] beta_first_reg, beta_second_reg;
    logic [23:0] learning_rate_reg, epsilon_reg;
    logic [32:0] pow1_reg, pow2_reg;
    logic [48:0] prod1, prod2;

    // Clearing pass.
    logic          clear_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Handshake.
    logic adv, accept, res_valid_reg;
    logic item_inside;

    // Stage A: memory read, gradient square, corrections.
    logic                   a_valid_reg;
    adam_pkg::tag_t         a_tag_reg;
    logic signed [31:0]     a_g_reg;
    logic [31:0]            a_gsq_reg;
    logic [32:0]            a_c1_reg, a_c2_reg;
    logic [31:0]            m_rd_reg, v_rd_reg;
    logic signed [63:0]     gg;
    logic [31:0]            gsq;

    // Stage B: moment update.
    logic                   b_valid_reg;
    adam_pkg::tag_t         b_tag_reg;
    logic signed [31:0]     b_m_reg;
    logic [31:0]            b_v_reg;
    logic [32:0]            b_c1_reg, b_c2_reg;
    logic                   fwd;
    logic signed [31:0]     m_old, m_new;
    logic [31:0]            v_old, v_new;
    logic signed [17:0]     b1_s, b1c_s;
    logic signed [49:0]     m_sum;
    logic signed [33:0]     m_sh;
    logic [16:0]            b2c;
    logic [49:0]            v_sum;
    logic [33:0]            v_sh;

    // Moment stores.
    logic [31:0]   m_mem [MEM_DEPTH];
    logic [31:0]   v_mem [MEM_DEPTH];
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [31:0]   m_wdata, v_wdata;

    // Stage C: magnitude.
    logic           c_valid_reg;
    adam_pkg::tag_t c_tag_reg;
    logic [31:0]    c_mag_reg, c_v_reg;
    logic [32:0]    c_c1_reg, c_c2_reg;

    // Correction dividers.
    logic           d_valid_reg [N1];
    adam_pkg::tag_t d_tag_reg [N1];
    logic [32:0]    d_rm_reg [N1], d_rm_next [N1];
    logic [32:0]    d_rv_reg [N1], d_rv_next [N1];
    logic [47:0]    d_qm_reg [N1], d_qm_next [N1];
    logic [47:0]    d_qv_reg [N1], d_qv_next [N1];
    logic [15:0]    d_mlo_reg [N1], d_mlo_next [N1];
    logic [15:0]    d_vlo_reg [N1], d_vlo_next [N1];
    logic [32:0]    d_c1_reg [N1], d_c1_next [N1];
    logic [32:0]    d_c2_reg [N1], d_c2_next [N1];
    adam_pkg::tag_t d_tag_next [N1];

    // Square root.
    logic           s_valid_reg [NS];
    adam_pkg::tag_t s_tag_reg [NS], s_tag_next [NS];
    logic [33:0]    s_rem_reg [NS], s_rem_next [NS];
    logic [31:0]    s_root_reg [NS], s_root_next [NS];
    logic [47:0]    s_x_reg [NS], s_x_next [NS];
    logic [47:0]    s_mhat_reg [NS], s_mhat_next [NS];

    // Stages E and F: denominator and product; the saturation test feeds the step divider.
    logic           e_valid_reg, f_valid_reg;
    adam_pkg::tag_t e_tag_reg, f_tag_reg;
    logic [40:0]    e_den_reg, f_den_reg;
    logic [47:0]    e_pplo_reg, e_pphi_reg;
    logic [71:0]    f_p_reg;
    logic [40:0]    den_sum;

    // Step divider.
    logic           q_valid_reg [N2];
    adam_pkg::tag_t q_tag_reg [N2], q_tag_next [N2];
    logic           q_sat_reg [N2], q_sat_next [N2];
    logic [40:0]    q_den_reg [N2], q_den_next [N2];
    logic [40:0]    q_rem_reg [N2], q_rem_next [N2];
    logic [30:0]    q_low_reg [N2], q_low_next [N2];
    logic [30:0]    q_q_reg [N2], q_q_next [N2];

    // Output.
    logic [adam_pkg::IDX_W-1:0] out_index_reg;
    logic signed [31:0]         velocity_reg;
    logic                       out_last_reg;
    logic signed [31:0]         vel_next;

    assign adv          = !res_valid_reg || result_ready;
    assign item_ready   = adv && !clear_reg;
    assign accept       = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign item_inside  = 32'(weight_addr) < WEIGHT_COUNT;
    assign result_valid = res_valid_reg;
    assign out_index    = out_index_reg;
    assign velocity     = velocity_reg;
    assign out_last     = out_last_reg;

    assign prod1 = pow1_reg * beta_first_reg;
    assign prod2 = pow2_reg * beta_second_reg;

    always_comb
    begin
        gg  = 64'(gradient) * 64'(gradient);
        gsq = (gg[63:48] != 16'd0) ? 32'hFFFF_FFFF : gg[47:16];
    end

    always_comb
    begin
        fwd   = b_valid_reg && b_tag_reg.in_range && (b_tag_reg.idx == a_tag_reg.idx);
        m_old = fwd ? b_m_reg : $signed(m_rd_reg);
        v_old = fwd ? b_v_reg : v_rd_reg;
        b1_s  = {2'b00, beta_first_reg};
        b1c_s = 18'sd65536 - b1_s;
        m_sum = b1_s * m_old + b1c_s * a_g_reg;
        m_sh  = m_sum[49:16];
        b2c   = 17'd65536 - {1'b0, beta_second_reg};
        v_sum = beta_second_reg * v_old + b2c * a_gsq_reg;
        v_sh  = v_sum[49:16];
        if (m_sh > 34'sd2147483647)
        begin
            m_new = 32'sh7FFF_FFFF;
        end
        else if (m_sh < -34'sd2147483648)
        begin
            m_new = 32'sh8000_0000;
        end
        else
        begin
            m_new = m_sh[31:0];
        end
        v_new = (v_sh[33:32] != 2'b00) ? 32'hFFFF_FFFF : v_sh[31:0];
        if (!a_tag_reg.in_range)
        begin
            m_new = '0;
            v_new = '0;
        end
    end

    assign mem_we  = clear_reg || (adv && a_valid_reg && a_tag_reg.in_range);
    assign wr_addr = clear_reg ? clr_cnt_reg : a_tag_reg.idx[AW-1:0];
    assign m_wdata = clear_reg ? 32'd0 : m_new;
    assign v_wdata = clear_reg ? 32'd0 : v_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            m_mem[wr_addr] <= m_wdata;
            v_mem[wr_addr] <= v_wdata;
        end
        if (adv)
        begin
            m_rd_reg <= m_mem[weight_addr[AW-1:0]];
            v_rd_reg <= v_mem[weight_addr[AW-1:0]];
        end
    end

    always_comb
    begin
        for (int k = 0; k < N1; k++)
        begin
            logic [32:0]    rm, rv, c1, c2;
            logic [47:0]    qm, qv;
            logic [15:0]    ml, vl;
            adam_pkg::tag_t tg;
            logic [33:0]    sm, sv;
            if (k == 0)
            begin
                rm = {17'd0, c_mag_reg[31:16]};
                rv = {17'd0, c_v_reg[31:16]};
                ml = c_mag_reg[15:0];
                vl = c_v_reg[15:0];
                qm = '0;
                qv = '0;
                c1 = c_c1_reg;
                c2 = c_c2_reg;
                tg = c_tag_reg;
            end
            else
            begin
                rm = d_rm_reg[k-1];
                rv = d_rv_reg[k-1];
                ml = d_mlo_reg[k-1];
                vl = d_vlo_reg[k-1];
                qm = d_qm_reg[k-1];
                qv = d_qv_reg[k-1];
                c1 = d_c1_reg[k-1];
                c2 = d_c2_reg[k-1];
                tg = d_tag_reg[k-1];
            end
            sm            = div_step(rm, ml[15], c1);
            sv            = div_step(rv, vl[15], c2);
            d_rm_next[k]  = sm[32:0];
            d_rv_next[k]  = sv[32:0];
            d_qm_next[k]  = {qm[46:0], sm[33]};
            d_qv_next[k]  = {qv[46:0], sv[33]};
            d_mlo_next[k] = {ml[14:0], 1'b0};
            d_vlo_next[k] = {vl[14:0], 1'b0};
            d_c1_next[k]  = c1;
            d_c2_next[k]  = c2;
            d_tag_next[k] = tg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            logic [33:0]    rem;
            logic [31:0]    root;
            logic [47:0]    x, mh;
            adam_pkg::tag_t tg;
            logic [35:0]    part;
            logic [35:0]    trial;
            logic           ge;
            if (k == 0)
            begin
                rem  = '0;
                root = '0;
                x    = d_qv_reg[N1-1];
                mh   = d_qm_reg[N1-1];
                tg   = d_tag_reg[N1-1];
            end
            else
            begin
                rem  = s_rem_reg[k-1];
                root = s_root_reg[k-1];
                x    = s_x_reg[k-1];
                mh   = s_mhat_reg[k-1];
                tg   = s_tag_reg[k-1];
            end
            part           = {rem, x[47:46]};
            trial          = {2'b00, root, 2'b01};
            ge             = part >= trial;
            s_rem_next[k]  = 34'(ge ? part - trial : part);
            s_root_next[k] = {root[30:0], ge};
            s_x_next[k]    = {x[45:0], 2'b00};
            s_mhat_next[k] = mh;
            s_tag_next[k]  = tg;
        end
    end

    assign den_sum = {1'b0, s_root_reg[NS-1], 8'd0} + {17'd0, epsilon_reg};

    always_comb
    begin
        for (int k = 0; k < N2; k++)
        begin
            logic [40:0]    rem, den;
            logic [30:0]    low, q;
            logic           sat;
            adam_pkg::tag_t tg;
            logic [41:0]    part;
            logic           ge;
            if (k == 0)
            begin
                rem = f_p_reg[71:31];
                low = f_p_reg[30:0];
                q   = '0;
                den = f_den_reg;
                sat = f_p_reg >= {f_den_reg, 31'd0};
                tg  = f_tag_reg;
            end
            else
            begin
                rem = q_rem_reg[k-1];
                low = q_low_reg[k-1];
                q   = q_q_reg[k-1];
                den = q_den_reg[k-1];
                sat = q_sat_reg[k-1];
                tg  = q_tag_reg[k-1];
            end
            part          = {rem, low[30]};
            ge            = part >= {1'b0, den};
            q_rem_next[k] = 41'(ge ? part - {1'b0, den} : part);
            q_low_next[k] = {low[29:0], 1'b0};
            q_q_next[k]   = {q[29:0], ge};
            q_den_next[k] = den;
            q_sat_next[k] = sat;
            q_tag_next[k] = tg;
        end
    end

    always_comb
    begin
        if (q_sat_reg[N2-1])
        begin
            vel_next = q_tag_reg[N2-1].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else if (q_tag_reg[N2-1].neg)
        begin
            vel_next = 32'd0 - {1'b0, q_q_reg[N2-1]};
        end
        else
        begin
            vel_next = {1'b0, q_q_reg[N2-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_first_reg    <= adam_pkg::BETA_FIRST_RESET;
            beta_second_reg   <= adam_pkg::BETA_SECOND_RESET;
            learning_rate_reg <= adam_pkg::LEARNING_RATE_RESET;
            epsilon_reg       <= adam_pkg::EPSILON_RESET;
            pow1_reg          <= adam_pkg::ONE_Q32;
            pow2_reg          <= adam_pkg::ONE_Q32;
            clear_reg         <= 1'b1;
            clr_cnt_reg       <= '0;
            a_valid_reg       <= 1'b0;
            b_valid_reg       <= 1'b0;
            c_valid_reg       <= 1'b0;
            e_valid_reg       <= 1'b0;
            f_valid_reg       <= 1'b0;
            res_valid_reg     <= 1'b0;
            for (int k = 0; k < N1; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < NS; k++)
            begin
                s_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < N2; k++)
            begin
                q_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    adam_pkg::REG_BETA_FIRST:    beta_first_reg    <= cfg_data[15:0];
                    adam_pkg::REG_BETA_SECOND:   beta_second_reg   <= cfg_data[15:0];
                    adam_pkg::REG_LEARNING_RATE: learning_rate_reg <= cfg_data;
                    adam_pkg::REG_EPSILON:       epsilon_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && last_of_vector)
            begin
                pow1_reg <= prod1[48:16];
                pow2_reg <= prod2[48:16];
            end
            if (clear_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                a_valid_reg <= accept;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                d_valid_reg[0] <= c_valid_reg;
                for (int k = 1; k < N1; k++)
                begin
                    d_valid_reg[k] <= d_valid_reg[k-1];
                end
                s_valid_reg[0] <= d_valid_reg[N1-1];
                for (int k = 1; k < NS; k++)
                begin
                    s_valid_reg[k] <= s_valid_reg[k-1];
                end
                e_valid_reg <= s_valid_reg[NS-1];
                f_valid_reg <= e_valid_reg;
                q_valid_reg[0] <= f_valid_reg;
                for (int k = 1; k < N2; k++)
                begin
                    q_valid_reg[k] <= q_valid_reg[k-1];
                end
                res_valid_reg <= q_valid_reg[N2-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_tag_reg.idx      <= weight_addr;
            a_tag_reg.last     <= last_of_vector;
            a_tag_reg.in_range <= item_inside;
            a_tag_reg.neg      <= 1'b0;
            a_g_reg            <= gradient;
            a_gsq_reg          <= gsq;
            a_c1_reg           <= adam_pkg::ONE_Q32 - prod1[48:16];
            a_c2_reg           <= adam_pkg::ONE_Q32 - prod2[48:16];

            b_tag_reg <= a_tag_reg;
            b_m_reg   <= m_new;
            b_v_reg   <= v_new;
            b_c1_reg  <= a_c1_reg;
            b_c2_reg  <= a_c2_reg;

            c_tag_reg <= {b_tag_reg.idx, b_tag_reg.last, b_tag_reg.in_range, b_m_reg[31]};
            c_mag_reg <= b_m_reg[31] ? 32'd0 - b_m_reg : b_m_reg;
            c_v_reg   <= b_v_reg;
            c_c1_reg  <= b_c1_reg;
            c_c2_reg  <= b_c2_reg;

            for (int k = 0; k < N1; k++)
            begin
                d_tag_reg[k] <= d_tag_next[k];
                d_rm_reg[k]  <= d_rm_next[k];
                d_rv_reg[k]  <= d_rv_next[k];
                d_qm_reg[k]  <= d_qm_next[k];
                d_qv_reg[k]  <= d_qv_next[k];
                d_mlo_reg[k] <= d_mlo_next[k];
                d_vlo_reg[k] <= d_vlo_next[k];
                d_c1_reg[k]  <= d_c1_next[k];
                d_c2_reg[k]  <= d_c2_next[k];
            end
            for (int k = 0; k < NS; k++)
            begin
                s_tag_reg[k]  <= s_tag_next[k];
                s_rem_reg[k]  <= s_rem_next[k];
                s_root_reg[k] <= s_root_next[k];
                s_x_reg[k]    <= s_x_next[k];
                s_mhat_reg[k] <= s_mhat_next[k];
            end

            e_tag_reg  <= s_tag_reg[NS-1];
            e_den_reg  <= (den_sum == 41'd0) ? 41'd1 : den_sum;
            e_pplo_reg <= s_mhat_reg[NS-1][23:0] * learning_rate_reg;
            e_pphi_reg <= s_mhat_reg[NS-1][47:24] * learning_rate_reg;

            f_tag_reg <= e_tag_reg;
            f_den_reg <= e_den_reg;
            f_p_reg   <= {e_pphi_reg, 24'd0} + {24'd0, e_pplo_reg};

            for (int k = 0; k < N2; k++)
            begin
                q_tag_reg[k] <= q_tag_next[k];
                q_sat_reg[k] <= q_sat_next[k];
                q_den_reg[k] <= q_den_next[k];
                q_rem_reg[k] <= q_rem_next[k];
                q_low_reg[k] <= q_low_next[k];
                q_q_reg[k]   <= q_q_next[k];
            end

            out_index_reg <= q_tag_reg[N2-1].idx;
            out_last_reg  <= q_tag_reg[N2-1].last;
            velocity_reg  <= vel_next;
        end
    end

    // The store is never handed to an item while it is being cleared.
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !item_ready && !a_valid_reg)
        else $error("item taken during the clearing pass");

    // Step powers never rise above one.
    a_pow1_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pow1_reg <= adam_pkg::ONE_Q32)
        else $error("first power above one");

    a_pow2_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pow2_reg <= adam_pkg::ONE_Q32)
        else $error("second power above one");

    // Without saturation the step divider keeps its partial remainder below the divisor.
    a_step_rem: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg[0] && !q_sat_reg[0] |-> q_rem_reg[0] < q_den_reg[0])
        else $error("step divider remainder out of range");

    // A stalled result stage holds its valid bit into the next cycle.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result_ready |=> res_valid_reg)
        else $error("result dropped under stall");

endmodule

`default_nettype wire
